[sv/tcf_pkg.sv]
package tcf_pkg;

    localparam logic [2:0] CMD_RECV    = 3'd0;
    localparam logic [2:0] CMD_CONNECT = 3'd1;
    localparam logic [2:0] CMD_SEND    = 3'd2;
    localparam logic [2:0] CMD_CLOSE   = 3'd3;
    localparam logic [2:0] CMD_CLEANUP = 3'd4;

    localparam logic [1:0] CFG_LOCAL_PORT  = 2'd0;
    localparam logic [1:0] CFG_REMOTE_PORT = 2'd1;
    localparam logic [1:0] CFG_REMOTE_IP   = 2'd2;
    localparam logic [1:0] CFG_INITIAL_SEQ = 2'd3;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_REFUSED = 2'd1;
    localparam logic [1:0] STATUS_DROPPED = 2'd2;

    localparam logic [7:0] FLAG_FIN = 8'h01;
    localparam logic [7:0] FLAG_SYN = 8'h02;
    localparam logic [7:0] FLAG_ACK = 8'h10;

    localparam logic [15:0] HEADER_BYTES = 16'd40;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_DROP,
        OP_SEGMENT,
        OP_CONNECT,
        OP_SEND,
        OP_CLOSE,
        OP_CLEANUP
    } t_op;

    typedef struct packed {
        logic [15:0] local_port;
        logic [15:0] remote_port;
        logic [31:0] remote_ip;
        logic [31:0] initial_seq;
    } t_cfg;

    typedef struct packed {
        t_op         op;
        logic        synack;
        logic        fin;
        logic        ack;
        logic [15:0] plen;
        logic [31:0] seg_seq;
        logic [7:0]  send_flags;
        logic [15:0] send_length;
    } t_item;

    typedef struct packed {
        logic        emit;
        logic [7:0]  out_flags;
        logic [31:0] out_seq;
        logic [31:0] out_ack;
        logic [15:0] out_length;
        logic        deliver;
        logic [1:0]  status;
        logic        is_open;
        logic        is_closing;
    } t_result;

endpackage

[sv/tcp_client_connection_fsm.sv]
// an accepted word is written into the queue, and its result is registered in the back end when it is popped
// throughput: one word per cycle while the output is not stalled, set by the state update in the back end
// a QUEUE_DEPTH entry queue between classifier and state update absorbs output stalls
// reset: synchronous active-low, clears connection state, registers, queue and output valid
module tcp_client_connection_fsm #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_cmd,
    input  logic [31:0] i_seg_src_ip,
    input  logic [15:0] i_seg_src_port,
    input  logic [15:0] i_seg_dst_port,
    input  logic [7:0]  i_seg_flags,
    input  logic [31:0] i_seg_seq,
    input  logic [15:0] i_seg_ip_length,
    input  logic [7:0]  i_send_flags,
    input  logic [15:0] i_send_length,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_emit,
    output logic [7:0]  o_out_flags,
    output logic [31:0] o_out_seq,
    output logic [31:0] o_out_ack,
    output logic [15:0] o_out_length,
    output logic        o_deliver,
    output logic [1:0]  o_status,
    output logic        o_is_open,
    output logic        o_is_closing
);

    tcf_pkg::t_cfg    r_cfg;
    tcf_pkg::t_item   front_item;
    tcf_pkg::t_item   queue_item;
    tcf_pkg::t_result result;
    logic             push;
    logic             queue_ready;
    logic             queue_valid;
    logic             pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tcf_pkg::CFG_LOCAL_PORT:  r_cfg.local_port  <= i_cfg_data[15:0];
                tcf_pkg::CFG_REMOTE_PORT: r_cfg.remote_port <= i_cfg_data[15:0];
                tcf_pkg::CFG_REMOTE_IP:   r_cfg.remote_ip   <= i_cfg_data;
                tcf_pkg::CFG_INITIAL_SEQ: r_cfg.initial_seq <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    tcf_front u_front (
        .i_cfg           (r_cfg),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_cmd           (i_cmd),
        .i_seg_src_ip    (i_seg_src_ip),
        .i_seg_src_port  (i_seg_src_port),
        .i_seg_dst_port  (i_seg_dst_port),
        .i_seg_flags     (i_seg_flags),
        .i_seg_seq       (i_seg_seq),
        .i_seg_ip_length (i_seg_ip_length),
        .i_send_flags    (i_send_flags),
        .i_send_length   (i_send_length),
        .o_push          (push),
        .o_item          (front_item),
        .i_queue_ready   (queue_ready)
    );

    tcf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_ready (queue_ready),
        .o_valid (queue_valid),
        .o_item  (queue_item),
        .i_pop   (pop)
    );

    tcf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (queue_valid),
        .i_item      (queue_item),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (result)
    );

    assign o_emit       = result.emit;
    assign o_out_flags  = result.out_flags;
    assign o_out_seq    = result.out_seq;
    assign o_out_ack    = result.out_ack;
    assign o_out_length = result.out_length;
    assign o_deliver    = result.deliver;
    assign o_status     = result.status;
    assign o_is_open    = result.is_open;
    assign o_is_closing = result.is_closing;

endmodule

[sv/tcf_front.sv]
module tcf_front (
    input  tcf_pkg::t_cfg  i_cfg,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic [2:0]     i_cmd,
    input  logic [31:0]    i_seg_src_ip,
    input  logic [15:0]    i_seg_src_port,
    input  logic [15:0]    i_seg_dst_port,
    input  logic [7:0]     i_seg_flags,
    input  logic [31:0]    i_seg_seq,
    input  logic [15:0]    i_seg_ip_length,
    input  logic [7:0]     i_send_flags,
    input  logic [15:0]    i_send_length,
    output logic           o_push,
    output tcf_pkg::t_item o_item,
    input  logic           i_queue_ready
);

    logic addr_match;

    assign o_in_ready = i_queue_ready;
    assign o_push     = i_in_valid && i_queue_ready;

    assign addr_match = (i_seg_src_ip == i_cfg.remote_ip)
                     && (i_seg_src_port == i_cfg.remote_port)
                     && (i_seg_dst_port == i_cfg.local_port);

    always_comb begin
        case (i_cmd)
            tcf_pkg::CMD_RECV:    o_item.op = addr_match ? tcf_pkg::OP_SEGMENT
                                                         : tcf_pkg::OP_DROP;
            tcf_pkg::CMD_CONNECT: o_item.op = tcf_pkg::OP_CONNECT;
            tcf_pkg::CMD_SEND:    o_item.op = tcf_pkg::OP_SEND;
            tcf_pkg::CMD_CLOSE:   o_item.op = tcf_pkg::OP_CLOSE;
            tcf_pkg::CMD_CLEANUP: o_item.op = tcf_pkg::OP_CLEANUP;
            default:              o_item.op = tcf_pkg::OP_NOP;
        endcase
        o_item.synack      = ((i_seg_flags & tcf_pkg::FLAG_SYN) != 8'd0)
                          && ((i_seg_flags & tcf_pkg::FLAG_ACK) != 8'd0);
        o_item.fin         = (i_seg_flags & tcf_pkg::FLAG_FIN) != 8'd0;
        o_item.ack         = (i_seg_flags & tcf_pkg::FLAG_ACK) != 8'd0;
        o_item.plen        = (i_seg_ip_length > tcf_pkg::HEADER_BYTES)
                           ? i_seg_ip_length - tcf_pkg::HEADER_BYTES : 16'd0;
        o_item.seg_seq     = i_seg_seq;
        o_item.send_flags  = i_send_flags;
        o_item.send_length = i_send_length;
    end

endmodule

[sv/tcf_queue.sv]
module tcf_queue #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tcf_pkg::t_item i_item,
    output logic           o_ready,
    output logic           o_valid,
    output tcf_pkg::t_item o_item,
    input  logic           i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tcf_pkg::t_item r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_ready = r_count != CNT_W'(DEPTH);
    assign o_valid = r_count != CNT_W'(0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

[sv/tcf_back.sv]
module tcf_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tcf_pkg::t_cfg    i_cfg,
    input  logic             i_valid,
    input  tcf_pkg::t_item   i_item,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output tcf_pkg::t_result o_result
);

    logic [31:0] r_send_seq, n_send_seq;
    logic [31:0] r_recv_ack, n_recv_ack;
    logic        r_exists, n_exists;
    logic        r_open, n_open;
    logic        r_closing, n_closing;
    logic        r_out_valid;
    tcf_pkg::t_result r_result, n_result;

    logic        take_synack;
    logic        fin_inc;
    logic [31:0] ack_sum;
    logic        can_send;

    assign o_pop       = i_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    assign take_synack = i_item.synack && !r_open;
    assign fin_inc     = i_item.fin && !take_synack;
    assign ack_sum     = r_recv_ack + 32'(i_item.plen) + 32'(fin_inc);
    assign can_send    = r_open && !r_closing;

    always_comb begin
        n_send_seq = r_send_seq;
        n_recv_ack = r_recv_ack;
        n_exists   = r_exists;
        n_open     = r_open;
        n_closing  = r_closing;
        n_result   = '0;
        case (i_item.op)
            tcf_pkg::OP_DROP: begin
                n_result.status = tcf_pkg::STATUS_DROPPED;
            end
            tcf_pkg::OP_SEGMENT: begin
                // segments for a connection that does not exist are dropped
                if (!r_exists) begin
                    n_result.status = tcf_pkg::STATUS_DROPPED;
                end else begin
                    if (take_synack) begin
                        n_recv_ack         = i_item.seg_seq + 32'd1;
                        n_send_seq         = r_send_seq + 32'd1;
                        n_open             = 1'b1;
                        n_result.emit      = 1'b1;
                        n_result.out_flags = tcf_pkg::FLAG_ACK;
                    end else if (i_item.fin) begin
                        n_recv_ack    = ack_sum;
                        n_open        = 1'b0;
                        n_closing     = 1'b0;
                        n_result.emit = 1'b1;
                        if (r_closing) begin
                            n_send_seq         = r_send_seq + 32'd1;
                            n_result.out_flags = tcf_pkg::FLAG_ACK;
                        end else begin
                            n_result.out_flags = tcf_pkg::FLAG_ACK | tcf_pkg::FLAG_FIN;
                        end
                    end else begin
                        n_recv_ack = ack_sum;
                        if (i_item.ack && (i_item.plen != 16'd0)) begin
                            n_result.emit      = 1'b1;
                            n_result.out_flags = tcf_pkg::FLAG_ACK;
                            n_result.deliver   = 1'b1;
                        end
                    end
                    if (n_result.emit) begin
                        n_result.out_seq = n_send_seq;
                        n_result.out_ack = n_recv_ack;
                    end
                end
            end
            tcf_pkg::OP_CONNECT: begin
                n_send_seq         = i_cfg.initial_seq;
                n_recv_ack         = 32'd0;
                n_exists           = 1'b1;
                n_open             = 1'b0;
                n_closing          = 1'b0;
                n_result.emit      = 1'b1;
                n_result.out_flags = tcf_pkg::FLAG_SYN;
                n_result.out_seq   = i_cfg.initial_seq;
            end
            tcf_pkg::OP_SEND: begin
                if (!can_send) begin
                    n_result.status = tcf_pkg::STATUS_REFUSED;
                end else begin
                    n_result.emit       = 1'b1;
                    n_result.out_flags  = i_item.send_flags;
                    n_result.out_seq    = r_send_seq;
                    n_result.out_ack    = r_recv_ack;
                    n_result.out_length = i_item.send_length;
                    n_send_seq          = r_send_seq + 32'(i_item.send_length);
                end
            end
            tcf_pkg::OP_CLOSE: begin
                if (!can_send) begin
                    n_result.status = tcf_pkg::STATUS_REFUSED;
                end else begin
                    n_closing          = 1'b1;
                    n_result.emit      = 1'b1;
                    n_result.out_flags = tcf_pkg::FLAG_FIN;
                    n_result.out_seq   = r_send_seq;
                    n_result.out_ack   = r_recv_ack;
                end
            end
            tcf_pkg::OP_CLEANUP: begin
                if (r_open) begin
                    n_result.status = tcf_pkg::STATUS_REFUSED;
                end else begin
                    n_exists = 1'b0;
                end
            end
            default: begin
            end
        endcase
        n_result.is_open    = n_open;
        n_result.is_closing = n_closing;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_send_seq  <= '0;
            r_recv_ack  <= '0;
            r_exists    <= 1'b0;
            r_open      <= 1'b0;
            r_closing   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_out_valid <= 1'b1;
                r_send_seq  <= n_send_seq;
                r_recv_ack  <= n_recv_ack;
                r_exists    <= n_exists;
                r_open      <= n_open;
                r_closing   <= n_closing;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= n_result;
        end
    end

endmodule

[sv/tcf_checker.sv]
module tcf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_emit,
    input logic [7:0]  o_out_flags,
    input logic [31:0] o_out_seq,
    input logic [31:0] o_out_ack,
    input logic [15:0] o_out_length,
    input logic        o_deliver,
    input logic [1:0]  o_status
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_emit)
            && $stable(o_out_seq) && $stable(o_out_ack) && $stable(o_status))
        else $error("stalled output word changed");

    a_no_emit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_emit |-> o_out_flags == 8'd0 && o_out_seq == 32'd0
            && o_out_ack == 32'd0 && o_out_length == 16'd0 && !o_deliver)
        else $error("header fields set without a segment");

    a_status_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != tcf_pkg::STATUS_OK |-> !o_emit
            && o_status != 2'd3)
        else $error("refused or dropped word sends a segment");

    a_deliver_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_deliver |-> o_emit && o_out_flags == tcf_pkg::FLAG_ACK
            && o_out_length == 16'd0)
        else $error("deliver without plain ack");

endmodule

bind tcp_client_connection_fsm tcf_checker u_tcf_checker (.*);

[tb/sv/tcp_client_connection_fsm_tb.sv]
module tcp_client_connection_fsm_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          LIMIT_CYCLES = 1_000_000;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          PHASE_WORDS  = 325;
    localparam int          SCRIPT_LEN   = 26;
    localparam logic [31:0] DIR_ISEQ     = 32'hFFFF_FFFF;

    // command codes the block ignores
    localparam logic [2:0] CMD_RSVD_LO = 3'd5;
    localparam logic [2:0] CMD_RSVD_HI = 3'd7;

    // addressing of a scripted segment
    localparam logic [1:0] ADDR_MATCH        = 2'd0;
    localparam logic [1:0] ADDR_BAD_SRC_PORT = 2'd1;
    localparam logic [1:0] ADDR_BAD_IP       = 2'd2;
    localparam logic [1:0] ADDR_BAD_DST_PORT = 2'd3;

    localparam logic [7:0] FLAG_SYNACK = 8'h12;
    localparam logic [7:0] FLAG_FINACK = 8'h11;

    localparam tcf_pkg::t_result SYN_REPLY = '{1'b1, tcf_pkg::FLAG_SYN, DIR_ISEQ, 32'h0, 16'h0,
                                               1'b0, tcf_pkg::STATUS_OK, 1'b0, 1'b0};

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] src_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  flags;
        logic [31:0] seq;
        logic [15:0] ip_len;
        logic [7:0]  tx_flags;
        logic [15:0] tx_len;
    } t_seg_word;

    typedef struct packed {
        logic [2:0]       cmd;
        logic [1:0]       addr;
        logic [7:0]       flags;
        logic [31:0]      seq;
        logic [15:0]      ip_len;
        logic [7:0]       tx_flags;
        logic [15:0]      tx_len;
        logic             typed;
        tcf_pkg::t_result reply;
    } t_script_row;

    typedef struct {
        logic [31:0] seq_num;
        logic [31:0] ack_num;
        logic        live;
        logic        up;
        logic        fin_sent;
    } t_conn_state;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [1:0]       cfg_index = '0;
    logic [31:0]      cfg_data = '0;
    logic             in_valid = 1'b0;
    logic             out_ready = 1'b0;
    t_seg_word        drv_word = '0;
    logic             drv_typed = 1'b0;
    tcf_pkg::t_result drv_typed_reply = '0;

    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_emit;
    logic [7:0]  o_out_flags;
    logic [31:0] o_out_seq;
    logic [31:0] o_out_ack;
    logic [15:0] o_out_length;
    logic        o_deliver;
    logic [1:0]  o_status;
    logic        o_is_open;
    logic        o_is_closing;

    tcf_pkg::t_cfg    peer_cfg = '0;
    t_conn_state      conn = '{32'h0, 32'h0, 1'b0, 1'b0, 1'b0};
    tcf_pkg::t_result replies_due[$];
    t_script_row      script [SCRIPT_LEN];
    int               fails = 0;
    int               cycles = 0;
    int               tx_calm = 0;
    logic             hold_off_now = 1'b0;

    tcp_client_connection_fsm i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_cmd           (drv_word.cmd),
        .i_seg_src_ip    (drv_word.src_ip),
        .i_seg_src_port  (drv_word.src_port),
        .i_seg_dst_port  (drv_word.dst_port),
        .i_seg_flags     (drv_word.flags),
        .i_seg_seq       (drv_word.seq),
        .i_seg_ip_length (drv_word.ip_len),
        .i_send_flags    (drv_word.tx_flags),
        .i_send_length   (drv_word.tx_len),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_emit          (o_emit),
        .o_out_flags     (o_out_flags),
        .o_out_seq       (o_out_seq),
        .o_out_ack       (o_out_ack),
        .o_out_length    (o_out_length),
        .o_deliver       (o_deliver),
        .o_status        (o_status),
        .o_is_open       (o_is_open),
        .o_is_closing    (o_is_closing)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic tcf_pkg::t_result outgoing(input logic [7:0] f,
                                                  input logic [15:0] n);
        tcf_pkg::t_result r;
        r = '0;
        r.emit = 1'b1;
        r.out_flags = f;
        r.out_seq = conn.seq_num;
        r.out_ack = conn.ack_num;
        r.out_length = n;
        return r;
    endfunction

    function automatic tcf_pkg::t_result quiet(input logic [1:0] st, input logic up,
                                               input logic closing);
        tcf_pkg::t_result r;
        r = '0;
        r.status = st;
        r.is_open = up;
        r.is_closing = closing;
        return r;
    endfunction

    // connection update for one accepted word, returns the reply it causes
    function automatic tcf_pkg::t_result advance_conn(input t_seg_word w);
        tcf_pkg::t_result r;
        logic [1:0]       st;
        logic [15:0]      payload;
        logic             has_ack;
        logic             has_syn;
        logic             has_fin;
        r = '0;
        st = tcf_pkg::STATUS_OK;
        has_ack = (w.flags & tcf_pkg::FLAG_ACK) != 8'h00;
        has_syn = (w.flags & tcf_pkg::FLAG_SYN) != 8'h00;
        has_fin = (w.flags & tcf_pkg::FLAG_FIN) != 8'h00;
        case (w.cmd)
            tcf_pkg::CMD_RECV: begin
                if (!conn.live || w.src_ip != peer_cfg.remote_ip ||
                    w.src_port != peer_cfg.remote_port ||
                    w.dst_port != peer_cfg.local_port) begin
                    st = tcf_pkg::STATUS_DROPPED;
                end else begin
                    payload = (w.ip_len > tcf_pkg::HEADER_BYTES)
                            ? w.ip_len - tcf_pkg::HEADER_BYTES : 16'd0;
                    conn.ack_num = conn.ack_num + {16'd0, payload};
                    if (has_ack && has_syn && !conn.up) begin
                        conn.ack_num = w.seq + 32'd1;
                        conn.seq_num = conn.seq_num + 32'd1;
                        r = outgoing(tcf_pkg::FLAG_ACK, 16'd0);
                        conn.up = 1'b1;
                    end else if (has_fin) begin
                        if (conn.fin_sent) begin
                            conn.seq_num = conn.seq_num + 32'd1;
                            conn.ack_num = conn.ack_num + 32'd1;
                            r = outgoing(tcf_pkg::FLAG_ACK, 16'd0);
                        end else begin
                            conn.ack_num = conn.ack_num + 32'd1;
                            r = outgoing(tcf_pkg::FLAG_ACK | tcf_pkg::FLAG_FIN, 16'd0);
                        end
                        conn.fin_sent = 1'b0;
                        conn.up = 1'b0;
                    end else if (has_ack && payload != 16'd0) begin
                        r = outgoing(tcf_pkg::FLAG_ACK, 16'd0);
                        r.deliver = 1'b1;
                    end
                end
            end
            tcf_pkg::CMD_CONNECT: begin
                conn.seq_num = peer_cfg.initial_seq;
                conn.ack_num = 32'h0;
                conn.live = 1'b1;
                conn.up = 1'b0;
                conn.fin_sent = 1'b0;
                r = outgoing(tcf_pkg::FLAG_SYN, 16'd0);
            end
            tcf_pkg::CMD_SEND: begin
                if (!conn.up || conn.fin_sent) begin
                    st = tcf_pkg::STATUS_REFUSED;
                end else begin
                    r = outgoing(w.tx_flags, w.tx_len);
                    conn.seq_num = conn.seq_num + {16'd0, w.tx_len};
                end
            end
            tcf_pkg::CMD_CLOSE: begin
                if (!conn.up || conn.fin_sent) begin
                    st = tcf_pkg::STATUS_REFUSED;
                end else begin
                    conn.fin_sent = 1'b1;
                    r = outgoing(tcf_pkg::FLAG_FIN, 16'd0);
                end
            end
            tcf_pkg::CMD_CLEANUP: begin
                if (conn.up)
                    st = tcf_pkg::STATUS_REFUSED;
                else
                    conn.live = 1'b0;
            end
            default: ;
        endcase
        r.status = st;
        r.is_open = conn.up;
        r.is_closing = conn.fin_sent;
        return r;
    endfunction

    // mostly well-formed session traffic with random content, some noise
    function automatic t_seg_word pick_word();
        t_seg_word w;
        int        roll;
        w.cmd = tcf_pkg::CMD_RECV;
        w.src_ip = peer_cfg.remote_ip;
        w.src_port = peer_cfg.remote_port;
        w.dst_port = peer_cfg.local_port;
        w.flags = tcf_pkg::FLAG_ACK;
        w.seq = $urandom();
        w.ip_len = 16'($urandom_range(41, 1500));
        w.tx_flags = 8'($urandom());
        if ($urandom_range(0, 19) == 0)
            w.tx_len = 16'($urandom());
        else
            w.tx_len = 16'($urandom_range(0, 1460));
        roll = $urandom_range(0, 99);
        if (!conn.live) begin
            if (roll < 75)
                w.cmd = tcf_pkg::CMD_CONNECT;
            else if (roll < 85)
                w.cmd = tcf_pkg::CMD_CLEANUP;
            else if (roll < 92)
                w.cmd = tcf_pkg::CMD_SEND;
        end else if (!conn.up) begin
            if (roll < 60)
                w.flags = FLAG_SYNACK;
            else if (roll < 75)
                w.cmd = tcf_pkg::CMD_CLEANUP;
            else if (roll < 85)
                w.cmd = tcf_pkg::CMD_CONNECT;
            else if (roll < 92)
                w.flags = tcf_pkg::FLAG_ACK;
            else
                w.cmd = tcf_pkg::CMD_CLOSE;
        end else if (!conn.fin_sent) begin
            if (roll < 35) begin
                w.flags = tcf_pkg::FLAG_ACK;
            end else if (roll < 45) begin
                w.ip_len = 16'($urandom_range(0, 40));
            end else if (roll < 70) begin
                w.cmd = tcf_pkg::CMD_SEND;
            end else if (roll < 78) begin
                w.cmd = tcf_pkg::CMD_CLOSE;
            end else if (roll < 85) begin
                w.flags = FLAG_FINACK;
            end else if (roll < 90) begin
                w.flags = FLAG_SYNACK;
            end else if (roll < 95) begin
                w.cmd = tcf_pkg::CMD_CLEANUP;
            end else begin
                w.cmd = tcf_pkg::CMD_CONNECT;
            end
        end else begin
            if (roll < 45)
                w.flags = FLAG_FINACK;
            else if (roll < 70)
                w.flags = tcf_pkg::FLAG_ACK;
            else if (roll < 82)
                w.cmd = tcf_pkg::CMD_SEND;
            else if (roll < 92)
                w.cmd = tcf_pkg::CMD_CLOSE;
            else
                w.cmd = tcf_pkg::CMD_CLEANUP;
        end
        // flag bits that do not steer the connection
        if ($urandom_range(0, 3) == 0)
            w.flags |= 8'($urandom()) & 8'hEC;
        roll = $urandom_range(0, 99);
        if (roll < 6) begin
            w.cmd = tcf_pkg::CMD_RECV;
            case ($urandom_range(0, 2))
                0: w.src_ip ^= 32'h1 << $urandom_range(0, 31);
                1: w.src_port ^= 16'h1 << $urandom_range(0, 15);
                default: w.dst_port ^= 16'h1 << $urandom_range(0, 15);
            endcase
        end else if (roll < 14) begin
            w.cmd = 3'($urandom_range(0, 7));
            w.flags = 8'($urandom());
            w.ip_len = 16'($urandom());
            w.tx_len = 16'($urandom());
            if ($urandom_range(0, 1) == 0) begin
                w.src_ip = $urandom();
                w.src_port = 16'($urandom());
                w.dst_port = 16'($urandom());
            end
        end
        return w;
    endfunction

    // idle length for either side, with occasional stretches of none
    function automatic int idle_len(inout int calm);
        int roll;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        roll = $urandom_range(0, 999);
        if (roll < 8) begin
            calm = $urandom_range(40, 200);
            return 0;
        end
        if (roll < 600)
            return 0;
        if (roll < 970)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic string show(input tcf_pkg::t_result r);
        return $sformatf({"emit=%0b flags=%02h seq=%08h ack=%08h len=%04h dlv=%0b",
                          " st=%0d open=%0b closing=%0b"},
                         r.emit, r.out_flags, r.out_seq, r.out_ack, r.out_length,
                         r.deliver, r.status, r.is_open, r.is_closing);
    endfunction

    task automatic load_settings(input tcf_pkg::t_cfg c);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= tcf_pkg::CFG_LOCAL_PORT;
        cfg_data <= {16'($urandom()), c.local_port};
        @(negedge clk);
        cfg_index <= tcf_pkg::CFG_REMOTE_PORT;
        cfg_data <= {16'($urandom()), c.remote_port};
        @(negedge clk);
        cfg_index <= tcf_pkg::CFG_REMOTE_IP;
        cfg_data <= c.remote_ip;
        @(negedge clk);
        cfg_index <= tcf_pkg::CFG_INITIAL_SEQ;
        cfg_data <= c.initial_seq;
        @(negedge clk);
        cfg_we <= 1'b0;
        peer_cfg = c;
    endtask

    // row < 0 draws a random word
    task automatic offer(input int row);
        int          gap;
        t_script_row s;
        t_seg_word   w;
        @(negedge clk);
        gap = idle_len(tx_calm);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        if (row >= 0) begin
            s = script[row];
            w.cmd = s.cmd;
            w.src_ip = peer_cfg.remote_ip;
            w.src_port = peer_cfg.remote_port;
            w.dst_port = peer_cfg.local_port;
            case (s.addr)
                ADDR_BAD_SRC_PORT: w.src_port = ~peer_cfg.remote_port;
                ADDR_BAD_IP: w.src_ip = peer_cfg.remote_ip ^ 32'h8000_0001;
                ADDR_BAD_DST_PORT: w.dst_port = peer_cfg.local_port ^ 16'h0001;
                default: ;
            endcase
            w.flags = s.flags;
            w.seq = s.seq;
            w.ip_len = s.ip_len;
            w.tx_flags = s.tx_flags;
            w.tx_len = s.tx_len;
            drv_typed <= s.typed;
            drv_typed_reply <= s.reply;
        end else begin
            w = pick_word();
            drv_typed <= 1'b0;
        end
        drv_word <= w;
        in_valid <= 1'b1;
        do @(posedge clk); while (!o_in_ready);
    endtask

    task automatic drain(input int tail);
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    // predict on input acceptance, check on output acceptance
    always @(posedge clk) begin : scoreboard
        tcf_pkg::t_result want;
        tcf_pkg::t_result got;
        if (rst_n) begin
            if (in_valid && o_in_ready) begin
                want = advance_conn(drv_word);
                if (drv_typed)
                    want = drv_typed_reply;
                replies_due.push_back(want);
            end
            if (o_out_valid && out_ready) begin
                got = '{o_emit, o_out_flags, o_out_seq, o_out_ack, o_out_length,
                        o_deliver, o_status, o_is_open, o_is_closing};
                if (replies_due.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected word: %s", show(got));
                end else begin
                    want = replies_due.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("mismatch: want %s", show(want));
                            $display("          got  %s", show(got));
                        end
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles == LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side, long hold-off on request
    initial begin : receiver
        int calm;
        int n;
        calm = 0;
        forever begin
            @(negedge clk);
            if (hold_off_now) begin
                hold_off_now = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            n = idle_len(calm);
            if (n == 0) begin
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end
        end
    end

    initial begin : stimulus
        tcf_pkg::t_cfg c;
        int            counted;
        script[0]  = '{tcf_pkg::CMD_RECV, ADDR_MATCH, tcf_pkg::FLAG_ACK, 32'h0, 16'd40,
                       8'h00, 16'h0000,
                       1'b1, quiet(tcf_pkg::STATUS_DROPPED, 1'b0, 1'b0)};
        script[1]  = '{tcf_pkg::CMD_SEND, ADDR_MATCH, 8'h00, 32'h0, 16'd0, 8'hFF, 16'hFFFF,
                       1'b1, quiet(tcf_pkg::STATUS_REFUSED, 1'b0, 1'b0)};
        script[2]  = '{tcf_pkg::CMD_CLOSE, ADDR_MATCH, 8'h00, 32'h0, 16'd0, 8'h00, 16'h0000,
                       1'b1, quiet(tcf_pkg::STATUS_REFUSED, 1'b0, 1'b0)};
        script[3]  = '{tcf_pkg::CMD_CLEANUP, ADDR_MATCH, 8'h00, 32'h0, 16'd0, 8'h00, 16'h0000,
                       1'b1, quiet(tcf_pkg::STATUS_OK, 1'b0, 1'b0)};
        script[4]  = '{CMD_RSVD_HI, ADDR_MATCH, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 16'hFFFF,
                       1'b1, quiet(tcf_pkg::STATUS_OK, 1'b0, 1'b0)};
        script[5]  = '{tcf_pkg::CMD_CONNECT, ADDR_MATCH, 8'h00, 32'h0, 16'd0, 8'h00, 16'h0000,
                       1'b1, SYN_REPLY};
        script[6]  = '{tcf_pkg::CMD_RECV, ADDR_BAD_SRC_PORT, FLAG_SYNACK, 32'h0, 16'd40,
                       8'h00, 16'h0,
                       1'b1, quiet(tcf_pkg::STATUS_DROPPED, 1'b0, 1'b0)};
        script[7]  = '{tcf_pkg::CMD_RECV, ADDR_BAD_IP, FLAG_SYNACK, 32'h0, 16'd40,
                       8'h00, 16'h0,
                       1'b1, quiet(tcf_pkg::STATUS_DROPPED, 1'b0, 1'b0)};
        script[8]  = '{tcf_pkg::CMD_RECV, ADDR_BAD_DST_PORT, FLAG_SYNACK, 32'h0, 16'd40,
                       8'h00, 16'h0,
                       1'b1, quiet(tcf_pkg::STATUS_DROPPED, 1'b0, 1'b0)};
        script[9]  = '{tcf_pkg::CMD_SEND, ADDR_MATCH, 8'h00, 32'h0, 16'd0, 8'h10, 16'd100,
                       1'b1, quiet(tcf_pkg::STATUS_REFUSED, 1'b0, 1'b0)};
        script[10] = '{tcf_pkg::CMD_RECV, ADDR_MATCH, FLAG_SYNACK, 32'hFFFF_FFFF, 16'd40,
                       8'h00, 16'h0,
                       1'b0, '0};
        script[11] = '{tcf_pkg::CMD_RECV, ADDR_MATCH, tcf_pkg::FLAG_ACK, 32'h0, 16'hFFFF,
                       8'h00, 16'h0,
                       1'b0, '0};
        script[12] = '{tcf_pkg::CMD_RECV, ADDR_MATCH, tcf_pkg::FLAG_ACK, 32'h0, 16'd39,
                       8'h00, 16'h0,
                       1'b0, '0};
        script[13] = '{tcf_pkg::CMD_RECV, ADDR_MATCH, tcf_pkg::FLAG_ACK, 32'h0, 16'd0,
                       8'h00, 16'h0,
                       1'b0, '0};
        script[14] = '{tcf_pkg::CMD_RECV, ADDR_MATCH, 8'h00, 32'h0, 16'd41, 8'h00, 16'h0,
                       1'b0, '0};
        script[15] = '{tcf_pkg::CMD_SEND, ADDR_MATCH, 8'h00, 32'h0, 16'd0, 8'hFF, 16'hFFFF,
                       1'b0, '0};
        script[16] = '{tcf_pkg::CMD_SEND, ADDR_MATCH, 8'h00, 32'h0, 16'd0, 8'h00, 16'h0000,
                       1'b0, '0};
        script[17] = '{tcf_pkg::CMD_CLEANUP, ADDR_MATCH, 8'h00, 32'h0, 16'd0, 8'h00, 16'h0000,
                       1'b1, quiet(tcf_pkg::STATUS_REFUSED, 1'b1, 1'b0)};
        script[18] = '{tcf_pkg::CMD_CLOSE, ADDR_MATCH, 8'h00, 32'h0, 16'd0, 8'h00, 16'h0000,
                       1'b0, '0};
        script[19] = '{tcf_pkg::CMD_SEND, ADDR_MATCH, 8'h00, 32'h0, 16'd0, 8'h18, 16'd10,
                       1'b1, quiet(tcf_pkg::STATUS_REFUSED, 1'b1, 1'b1)};
        script[20] = '{tcf_pkg::CMD_RECV, ADDR_MATCH, FLAG_FINACK, 32'h0, 16'd40, 8'h00, 16'h0,
                       1'b0, '0};
        script[21] = '{tcf_pkg::CMD_CONNECT, ADDR_MATCH, 8'h00, 32'h0, 16'd0, 8'h00, 16'h0000,
                       1'b1, SYN_REPLY};
        script[22] = '{tcf_pkg::CMD_RECV, ADDR_MATCH, 8'hFF, 32'h1234_5678, 16'd100,
                       8'h00, 16'h0,
                       1'b0, '0};
        script[23] = '{tcf_pkg::CMD_RECV, ADDR_MATCH, tcf_pkg::FLAG_FIN, 32'h0, 16'd40,
                       8'h00, 16'h0,
                       1'b0, '0};
        script[24] = '{tcf_pkg::CMD_CLEANUP, ADDR_MATCH, 8'h00, 32'h0, 16'd0, 8'h00, 16'h0000,
                       1'b1, quiet(tcf_pkg::STATUS_OK, 1'b0, 1'b0)};
        script[25] = '{tcf_pkg::CMD_RECV, ADDR_MATCH, tcf_pkg::FLAG_ACK, 32'h0, 16'd100,
                       8'h00, 16'h0,
                       1'b1, quiet(tcf_pkg::STATUS_DROPPED, 1'b0, 1'b0)};

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        load_settings('{16'h1234, 16'h0050, 32'hC0A8_0001, DIR_ISEQ});
        for (int i = 0; i < SCRIPT_LEN; i++)
            offer(i);

        for (int p = 0; p < 6; p++) begin
            @(negedge clk);
            in_valid <= 1'b0;
            drain(4);
            case (p)
                1: c = '0;
                2: c = '1;
                default: c = '{16'($urandom()), 16'($urandom()), $urandom(), $urandom()};
            endcase
            load_settings(c);
            if (p == 1 || p == 4)
                hold_off_now = 1'b1;
            counted = 0;
            while (counted < PHASE_WORDS) begin
                offer(-1);
                if (drv_word.cmd <= tcf_pkg::CMD_CLEANUP)
                    counted++;
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        drain(10);
        if (fails == 0 && replies_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[tcp_client_connection_fsm.f]
sv/tcf_pkg.sv
sv/tcf_front.sv
sv/tcf_queue.sv
sv/tcf_back.sv
sv/tcp_client_connection_fsm.sv
sv/tcf_checker.sv
tb/sv/tcp_client_connection_fsm_tb.sv
